[rtl/brb_pkg.sv]
package brb_pkg;

   // Size of the byte store and the widths that follow from it.
   localparam int DEPTH = 256;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int LEN_W = PTR_W + 1;

   // Command queue between the front and the back.
   localparam int CQ_DEPTH = 2;
   localparam int CQ_IDX_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // Result queue at the output.
   localparam int OQ_DEPTH = 4;
   localparam int OQ_IDX_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   // Function codes as they arrive on the request port.
   localparam logic [1:0] FUNC_PUSH   = 2'd0;
   localparam logic [1:0] FUNC_COMMIT = 2'd1;
   localparam logic [1:0] FUNC_POP    = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_COMMIT,
      OP_POP,
      OP_CLEAR
   } op_type;

   // One decoded command word.
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic [7:0]       data_out;
      logic             ok;
      logic [LEN_W-1:0] committed_count;
      logic             overrun;
   } rsp_type;

endpackage

[rtl/byte_ring_buffer_with_commit_top.sv]
// Channel    Direction  Handshake            Word
// req        in         req_push / req_full  req_func, req_data_in
// rsp        out        rsp_empty / rsp_pop  rsp_data_out, rsp_ok, rsp_committed_count,
//                                            rsp_overrun
//
// One word is taken every cycle for as long as results are drained; the
// executor updates all pointers together and the byte store has one write
// and one registered read port. A request passes the command queue, the
// read stage and the result queue before its result shows on rsp. Reset is
// synchronous and needs no clearing pass: the store is only read where a
// push has written. A stalled rsp side fills the four-word result queue and
// then the two-word command queue before req_full rises.
module byte_ring_buffer_with_commit_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_func,
   input  logic [7:0]                  req_data_in,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [7:0]                  rsp_data_out,
   output logic                        rsp_ok,
   output logic [brb_pkg::LEN_W-1:0]   rsp_committed_count,
   output logic                        rsp_overrun
);

   logic                           cmd_valid;
   brb_pkg::cmd_type               cmd;
   logic                           cmd_take;
   logic [brb_pkg::OQ_CNT_W-1:0]   out_level;
   logic                           res_valid;
   brb_pkg::rsp_type               res;
   brb_pkg::rsp_type               head;

   // Front: accepts and classifies request words.
   brb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_func    (req_func),
      .req_data_in (req_data_in),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   // Back: executes commands on the byte store.
   brb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .out_level (out_level),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result queue towards the consumer.
   brb_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .level     (out_level),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (head)
   );

   assign rsp_data_out        = head.data_out;
   assign rsp_ok              = head.ok;
   assign rsp_committed_count = head.committed_count;
   assign rsp_overrun         = head.overrun;

endmodule

[rtl/brb_front.sv]
module brb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [1:0]          req_func,
   input  logic [7:0]          req_data_in,
   output logic                cmd_valid,
   output brb_pkg::cmd_type    cmd,
   input  logic                cmd_take
);

   brb_pkg::cmd_type               entry_ff [brb_pkg::CQ_DEPTH];
   logic [brb_pkg::CQ_IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [brb_pkg::CQ_IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [brb_pkg::CQ_CNT_W-1:0]   count_ff, count_in;
   brb_pkg::cmd_type               decoded;
   logic                           accept;
   logic                           take;

   // Classify the incoming function code.
   always_comb begin
      decoded.data = req_data_in;
      unique case (req_func)
         brb_pkg::FUNC_PUSH:   decoded.op = brb_pkg::OP_PUSH;
         brb_pkg::FUNC_COMMIT: decoded.op = brb_pkg::OP_COMMIT;
         brb_pkg::FUNC_POP:    decoded.op = brb_pkg::OP_POP;
         default:              decoded.op = brb_pkg::OP_CLEAR;
      endcase
   end

   assign req_full  = (count_ff == brb_pkg::CQ_CNT_W'(brb_pkg::CQ_DEPTH));
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != '0);
   assign take      = cmd_take && cmd_valid;
   assign cmd       = entry_ff[rd_idx_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_idx_in = (wr_idx_ff == brb_pkg::CQ_IDX_W'(brb_pkg::CQ_DEPTH - 1)) ?
                     '0 : wr_idx_ff + 1'b1;
      end
      if (take) begin
         rd_idx_in = (rd_idx_ff == brb_pkg::CQ_IDX_W'(brb_pkg::CQ_DEPTH - 1)) ?
                     '0 : rd_idx_ff + 1'b1;
      end
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_idx_ff] <= decoded;
      end
   end

endmodule

[rtl/brb_back.sv]
module brb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  brb_pkg::cmd_type              cmd,
   output logic                          cmd_take,
   input  logic [brb_pkg::OQ_CNT_W-1:0]  out_level,
   output logic                          res_valid,
   output brb_pkg::rsp_type              res
);

   logic [7:0]                  store_ff [brb_pkg::DEPTH];
   logic [7:0]                  rd_data_ff;
   logic [brb_pkg::PTR_W-1:0]   rp_ff, rp_in;
   logic [brb_pkg::PTR_W-1:0]   wp_ff, wp_in;
   logic [brb_pkg::PTR_W-1:0]   cwp_ff, cwp_in;
   logic [brb_pkg::LEN_W-1:0]   total_ff, total_in;
   logic [brb_pkg::LEN_W-1:0]   committed_ff, committed_in;
   logic                        ovr_ff, ovr_in;
   logic                        s2_valid_ff;
   logic                        s2_pop_ff;
   logic                        s2_ok_ff;
   logic [brb_pkg::LEN_W-1:0]   s2_count_ff;
   logic                        s2_ovr_ff;
   logic                        fire;
   logic                        wr_en;
   logic                        ok;
   logic                        pop_ok;

   function automatic logic [brb_pkg::PTR_W-1:0] next_index(
      input logic [brb_pkg::PTR_W-1:0] ptr
   );
      logic [brb_pkg::PTR_W-1:0] nxt;
      nxt = (ptr == brb_pkg::PTR_W'(brb_pkg::DEPTH - 1)) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   // Take a command only when the result queue has room for it and for
   // the word already in the read stage.
   assign fire = cmd_valid &&
                 (({1'b0, out_level} + {brb_pkg::OQ_CNT_W'(0), s2_valid_ff}) <
                  (brb_pkg::OQ_CNT_W + 1)'(brb_pkg::OQ_DEPTH));
   assign cmd_take = fire;

   // Execute one command against the pointers and lengths.
   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      cwp_in       = cwp_ff;
      total_in     = total_ff;
      committed_in = committed_ff;
      ovr_in       = ovr_ff;
      wr_en        = 1'b0;
      ok           = 1'b0;
      pop_ok       = 1'b0;
      if (fire) begin
         unique case (cmd.op)
            brb_pkg::OP_PUSH: begin
               if (!ovr_ff) begin
                  if (total_ff >= brb_pkg::LEN_W'(brb_pkg::DEPTH - 1)) begin
                     ovr_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wp_in    = next_index(wp_ff);
                     total_in = total_ff + 1'b1;
                     ok       = 1'b1;
                  end
               end
            end
            brb_pkg::OP_COMMIT: begin
               if (ovr_ff) begin
                  wp_in    = cwp_ff;
                  total_in = committed_ff;
                  ovr_in   = 1'b0;
               end else begin
                  cwp_in       = wp_ff;
                  committed_in = total_ff;
                  ok           = 1'b1;
               end
            end
            brb_pkg::OP_POP: begin
               if (committed_ff != '0) begin
                  ok     = 1'b1;
                  pop_ok = 1'b1;
                  if (total_ff <= brb_pkg::LEN_W'(1)) begin
                     rp_in        = '0;
                     wp_in        = '0;
                     cwp_in       = '0;
                     total_in     = '0;
                     committed_in = '0;
                     ovr_in       = 1'b0;
                  end else begin
                     rp_in        = next_index(rp_ff);
                     total_in     = total_ff - 1'b1;
                     committed_in = committed_ff - 1'b1;
                  end
               end
            end
            default: begin
               rp_in        = '0;
               wp_in        = '0;
               cwp_in       = '0;
               total_in     = '0;
               committed_in = '0;
               ovr_in       = 1'b0;
            end
         endcase
      end
   end

   // Control state and the read stage valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff        <= '0;
         wp_ff        <= '0;
         cwp_ff       <= '0;
         total_ff     <= '0;
         committed_ff <= '0;
         ovr_ff       <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         cwp_ff       <= cwp_in;
         total_ff     <= total_in;
         committed_ff <= committed_in;
         ovr_ff       <= ovr_in;
         s2_valid_ff  <= fire;
      end
   end

   // Read stage payload, held alongside the registered store output.
   always_ff @(posedge clock) begin
      if (fire) begin
         s2_pop_ff   <= pop_ok;
         s2_ok_ff    <= ok;
         s2_count_ff <= committed_in;
         s2_ovr_ff   <= ovr_in;
      end
   end

   // Byte store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wp_ff] <= cmd.data;
      end
      if (pop_ok) begin
         rd_data_ff <= store_ff[rp_ff];
      end
   end

   assign res_valid           = s2_valid_ff;
   assign res.data_out        = s2_pop_ff ? rd_data_ff : 8'd0;
   assign res.ok              = s2_ok_ff;
   assign res.committed_count = s2_count_ff;
   assign res.overrun         = s2_ovr_ff;

endmodule

[rtl/brb_out_queue.sv]
module brb_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   input  brb_pkg::rsp_type              res,
   output logic [brb_pkg::OQ_CNT_W-1:0]  level,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output brb_pkg::rsp_type              head
);

   brb_pkg::rsp_type               entry_ff [brb_pkg::OQ_DEPTH];
   logic [brb_pkg::OQ_IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [brb_pkg::OQ_IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [brb_pkg::OQ_CNT_W-1:0]   count_ff, count_in;
   logic                           take;

   assign rsp_empty = (count_ff == '0);
   assign take      = rsp_pop && !rsp_empty;
   assign level     = count_ff;
   assign head      = entry_ff[rd_idx_ff];

   // Pointers and fill level; the back end never writes into a full queue.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (res_valid) begin
         wr_idx_in = (wr_idx_ff == brb_pkg::OQ_IDX_W'(brb_pkg::OQ_DEPTH - 1)) ?
                     '0 : wr_idx_ff + 1'b1;
      end
      if (take) begin
         rd_idx_in = (rd_idx_ff == brb_pkg::OQ_IDX_W'(brb_pkg::OQ_DEPTH - 1)) ?
                     '0 : rd_idx_ff + 1'b1;
      end
      if (res_valid && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !res_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Result storage carries no reset.
   always_ff @(posedge clock) begin
      if (res_valid) begin
         entry_ff[wr_idx_ff] <= res;
      end
   end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 2000;
   localparam int SETTLE_CYCLES  = 10;

   // Block ports.
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [1:0]                  req_func = brb_pkg::FUNC_PUSH;
   logic [7:0]                  req_data_in = 8'h00;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [7:0]                  rsp_data_out;
   logic                        rsp_ok;
   logic [brb_pkg::LEN_W-1:0]   rsp_committed_count;
   logic                        rsp_overrun;

   // One row of the directed stimulus; a typed row carries its own expectation.
   typedef struct {
      logic [1:0]         func;
      logic [7:0]         data;
      bit                 typed;
      brb_pkg::rsp_type   want;
   } stim_row_type;

   stim_row_type dir_rows[$];

   // Results still owed by the block, oldest first.
   brb_pkg::rsp_type due_results[$];

   // Mirror of the ring state.
   logic [7:0]                  ring_mem [brb_pkg::DEPTH];
   logic [brb_pkg::PTR_W-1:0]   rd_ptr;
   logic [brb_pkg::PTR_W-1:0]   wr_ptr;
   logic [brb_pkg::PTR_W-1:0]   commit_wr_ptr;
   logic [brb_pkg::LEN_W-1:0]   total_len;
   logic [brb_pkg::LEN_W-1:0]   commit_len;
   logic                        ovr_flag;

   // Run statistics.
   int fail_count    = 0;
   int words_sent    = 0;
   int results_seen  = 0;
   int overrun_hits  = 0;
   int rollbacks     = 0;
   int ptr_wraps     = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   byte_ring_buffer_with_commit_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_func            (req_func),
      .req_data_in         (req_data_in),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_data_out        (rsp_data_out),
      .rsp_ok              (rsp_ok),
      .rsp_committed_count (rsp_committed_count),
      .rsp_overrun         (rsp_overrun)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Return the ring to its empty state; the stored bytes are kept.
   function automatic void ring_restart();
      rd_ptr        = '0;
      wr_ptr        = '0;
      commit_wr_ptr = '0;
      total_len     = '0;
      commit_len    = '0;
      ovr_flag      = 1'b0;
   endfunction

   function automatic logic [brb_pkg::PTR_W-1:0] ptr_next(
      input logic [brb_pkg::PTR_W-1:0] p
   );
      return (int'(p) == brb_pkg::DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   // Apply one operation to the mirror and return the word it should produce.
   function automatic brb_pkg::rsp_type ring_step(input logic [1:0] f, input logic [7:0] d);
      brb_pkg::rsp_type r;
      r = '0;
      case (f)
         brb_pkg::FUNC_PUSH: begin
            if (!ovr_flag) begin
               if (int'(total_len) + 1 >= brb_pkg::DEPTH) begin
                  ovr_flag = 1'b1;
                  overrun_hits++;
               end else begin
                  ring_mem[wr_ptr] = d;
                  if (int'(wr_ptr) == brb_pkg::DEPTH - 1) ptr_wraps++;
                  wr_ptr    = ptr_next(wr_ptr);
                  total_len = total_len + 1'b1;
                  r.ok      = 1'b1;
               end
            end
         end
         brb_pkg::FUNC_COMMIT: begin
            if (ovr_flag) begin
               wr_ptr    = commit_wr_ptr;
               total_len = commit_len;
               ovr_flag  = 1'b0;
               rollbacks++;
            end else begin
               commit_wr_ptr = wr_ptr;
               commit_len    = total_len;
               r.ok          = 1'b1;
            end
         end
         brb_pkg::FUNC_POP: begin
            if (commit_len != '0) begin
               r.data_out = ring_mem[rd_ptr];
               r.ok       = 1'b1;
               if (total_len <= 1) begin
                  ring_restart();
               end else begin
                  rd_ptr     = ptr_next(rd_ptr);
                  total_len  = total_len - 1'b1;
                  commit_len = commit_len - 1'b1;
               end
            end
         end
         default: begin
            ring_restart();
         end
      endcase
      r.committed_count = commit_len;
      r.overrun         = ovr_flag;
      return r;
   endfunction

   function automatic void add_row(input logic [1:0] f, input logic [7:0] d, input bit typed,
                                   input logic [7:0] e_data = 8'h00, input logic e_ok = 1'b0,
                                   input int e_cnt = 0, input logic e_ovr = 1'b0);
      stim_row_type row;
      row.func                 = f;
      row.data                 = d;
      row.typed                = typed;
      row.want.data_out        = e_data;
      row.want.ok              = e_ok;
      row.want.committed_count = brb_pkg::LEN_W'(e_cnt);
      row.want.overrun         = e_ovr;
      dir_rows.push_back(row);
   endfunction

   // Offer one word after a random gap and record what it should produce once taken.
   task automatic send_word(input logic [1:0] f, input logic [7:0] d,
                            input bit typed = 1'b0, input brb_pkg::rsp_type want = '0);
      brb_pkg::rsp_type guess;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_func    <= f;
      req_data_in <= d;
      @(posedge clock);
      while (req_full) @(posedge clock);
      guess = ring_step(f, d);
      due_results.push_back(typed ? want : guess);
      words_sent++;
   endtask

   // Hold the sender back until every outstanding result has been taken.
   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // Push near or past the ring's limit, mostly then commit or roll back, and pop zero or more.
   task automatic fill_ring();
      repeat ($urandom_range(250, 262)) send_word(brb_pkg::FUNC_PUSH, 8'($urandom));
      if ($urandom_range(0, 3) != 0) send_word(brb_pkg::FUNC_COMMIT, 8'($urandom));
      repeat ($urandom_range(0, 20)) send_word(brb_pkg::FUNC_POP, 8'($urandom));
   endtask

   // Mostly well-formed transactions with random bytes, plus fills, clears, pop bursts and noise.
   task automatic random_phase(input int n_words);
      int start;
      int kind;
      int n;
      start = words_sent;
      fill_ring();
      while (words_sent - start < n_words) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            n = $urandom_range(1, 12);
            repeat (n) send_word(brb_pkg::FUNC_PUSH, 8'($urandom));
            if ($urandom_range(0, 9) != 0) send_word(brb_pkg::FUNC_COMMIT, 8'($urandom));
            repeat ($urandom_range(0, n + 4)) send_word(brb_pkg::FUNC_POP, 8'($urandom));
         end else if (kind < 62) begin
            fill_ring();
         end else if (kind < 66) begin
            send_word(brb_pkg::FUNC_CLEAR, 8'($urandom));
         end else if (kind < 76) begin
            repeat ($urandom_range(1, 6)) send_word(brb_pkg::FUNC_POP, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8))
               send_word(2'($urandom_range(0, 3)), 8'($urandom));
         end
      end
      drain_results();
   endtask

   // Result side: random stalls on pop, and every taken word is checked.
   always @(posedge clock) begin
      brb_pkg::rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (due_results.size() == 0) begin
               flag_mismatch("result word arrived with nothing expected");
            end else begin
               want = due_results.pop_front();
               if (rsp_data_out !== want.data_out)
                  flag_mismatch($sformatf("data_out got %02h expected %02h",
                                          rsp_data_out, want.data_out));
               if (rsp_ok !== want.ok)
                  flag_mismatch($sformatf("ok got %b expected %b", rsp_ok, want.ok));
               if (rsp_committed_count !== want.committed_count)
                  flag_mismatch($sformatf("committed_count got %0d expected %0d",
                                          rsp_committed_count, want.committed_count));
               if (rsp_overrun !== want.overrun)
                  flag_mismatch($sformatf("overrun got %b expected %b",
                                          rsp_overrun, want.overrun));
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Stop the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("byte_ring_buffer_with_commit_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      ring_restart();

      // Directed words: empty-ring behaviour, byte extremes, commit, pop and clear.
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b1, 8'h00, 1'b0, 0, 1'b0);
      add_row(brb_pkg::FUNC_COMMIT, 8'h00, 1'b1, 8'h00, 1'b1, 0, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'h00, 1'b1, 8'h00, 1'b1, 0, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'hFF, 1'b1, 8'h00, 1'b1, 0, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'hA5, 1'b0);
      add_row(brb_pkg::FUNC_COMMIT, 8'hFF, 1'b1, 8'h00, 1'b1, 3, 1'b0);
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b1, 8'h00, 1'b1, 2, 1'b0);
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b1, 8'hFF, 1'b1, 1, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'h5A, 1'b0);
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b0);
      // Nothing committed is left, although one pending byte is stored.
      add_row(brb_pkg::FUNC_POP,    8'hFF, 1'b1, 8'h00, 1'b0, 0, 1'b0);
      add_row(brb_pkg::FUNC_COMMIT, 8'h00, 1'b0);
      // Popping the last stored byte returns the ring to its empty state.
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'h3C, 1'b0);
      add_row(brb_pkg::FUNC_CLEAR,  8'hFF, 1'b1, 8'h00, 1'b0, 0, 1'b0);
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b1, 8'h00, 1'b0, 0, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'h81, 1'b0);
      add_row(brb_pkg::FUNC_COMMIT, 8'h00, 1'b0);
      add_row(brb_pkg::FUNC_PUSH,   8'h7E, 1'b0);
      add_row(brb_pkg::FUNC_CLEAR,  8'h00, 1'b1, 8'h00, 1'b0, 0, 1'b0);
      add_row(brb_pkg::FUNC_POP,    8'h00, 1'b1, 8'h00, 1'b0, 0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // First phase: sender seldom idles, receiver mostly stalls.
      send_idle_pct  = 14;
      recv_stall_pct = 84;
      foreach (dir_rows[i])
         send_word(dir_rows[i].func, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      drain_results();
      random_phase(RANDOM_WORDS / 3);

      // Second phase: the other way round.
      send_idle_pct  = 84;
      recv_stall_pct = 14;
      random_phase(RANDOM_WORDS / 3);

      // Last phase: both sides at full rate.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_phase(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

      req_push <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d words sent, %0d result words checked, %0d mismatches.",
               words_sent, results_seen, fail_count);
      $display("Summary: %0d overruns, %0d rollbacks, %0d write pointer wraps.",
               overrun_hits, rollbacks, ptr_wraps);
      if (fail_count == 0) begin
         $display("byte_ring_buffer_with_commit_top test passed");
      end else begin
         $display("byte_ring_buffer_with_commit_top test failed");
      end
      $finish;
   end

endmodule
